/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Property given as an implication with an antecedent and a consequent.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

/* src/dps_pkg.sv */
package dps_pkg;

  localparam int POINTS    = 64;
  localparam int IDX_W     = $clog2(POINTS);
  localparam int SAMPLE_W  = 16;
  localparam int ROM_W     = 16;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = PROD_W + IDX_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int PART_W    = 32;
  localparam int POW_W     = 63;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TIME   = 1'b1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // Accumulated sums of one bin, passed from the MAC loop to the scaling unit.
  typedef struct packed {
    logic [IDX_W-1:0]        bin;
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } bin_sums_t;

  typedef logic [POINTS-1:0][ROM_W-1:0] rom_t;

  // Integer Taylor series in Q30 radians, rounded to Q1.15.
  function automatic logic signed [ROM_W-1:0] taylor_q15(logic [63:0] th, bit odd);
    logic [63:0]        t2;
    logic [63:0]        term;
    logic [63:0]        q;
    logic signed [63:0] acc;
    t2   = (th * th) >> 30;
    term = odd ? th : ONE_Q30;
    acc  = 64'sd0;
    for (int k = 0; k < 6; k++) begin
      if ((k % 2) == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
      q = (term * t2) >> 30;
      case (k)
        0: term = odd ? q / 6   : q / 2;
        1: term = odd ? q / 20  : q / 12;
        2: term = odd ? q / 42  : q / 30;
        3: term = odd ? q / 72  : q / 56;
        4: term = odd ? q / 110 : q / 90;
        default: term = odd ? q / 156 : q / 132;
      endcase
    end
    if (acc < 64'sd0) acc = 64'sd0;
    if (acc > $signed(ONE_Q30)) acc = $signed(ONE_Q30);
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > 64'sd32767) acc = 64'sd32767;
    return ROM_W'(acc);
  endfunction

  // Cosine or sine of 2*pi*m/POINTS for every m, folded by quadrant.
  function automatic rom_t build_rom(bit sine);
    rom_t                     rom;
    logic [63:0]              p;
    logic [63:0]              quad;
    logic [63:0]              x;
    logic [63:0]              th;
    logic signed [ROM_W-1:0]  s;
    logic signed [ROM_W-1:0]  c;
    logic signed [ROM_W-1:0]  sv;
    logic signed [ROM_W-1:0]  cv;
    for (int m = 0; m < POINTS; m++) begin
      p    = ((64'(m) << 24) + 64'(POINTS / 2)) / 64'(POINTS);
      quad = (p >> 22) & 64'd3;
      x    = p & 64'h3fffff;
      th   = (x * HALF_PI_Q30) >> 22;
      s    = taylor_q15(th, 1'b1);
      c    = taylor_q15(th, 1'b0);
      case (quad)
        64'd0: begin
          sv = s;
          cv = c;
        end
        64'd1: begin
          sv = c;
          cv = -s;
        end
        64'd2: begin
          sv = -s;
          cv = -c;
        end
        default: begin
          sv = -c;
          cv = s;
        end
      endcase
      rom[m] = sine ? sv : cv;
    end
    return rom;
  endfunction

  localparam rom_t COS_ROM = build_rom(1'b0);
  localparam rom_t SIN_ROM = build_rom(1'b1);

endpackage

/* src/dps_mac.sv */
module dps_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic signed [dps_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                                    sample_valid_i,
  output logic                                    sample_ready_o,
  output logic                                    sums_valid_o,
  input  logic                                    sums_ready_i,
  output dps_pkg::bin_sums_t                      sums_o
);

  localparam logic [dps_pkg::IDX_W-1:0] LAST = dps_pkg::IDX_W'(dps_pkg::POINTS - 1);

  logic signed [dps_pkg::SAMPLE_W-1:0] mem [dps_pkg::POINTS];

  logic                       run_q;
  logic [dps_pkg::IDX_W-1:0]  cnt_q;
  logic [dps_pkg::IDX_W-1:0]  bin_q;
  logic [dps_pkg::IDX_W-1:0]  j_q;
  logic [dps_pkg::IDX_W-1:0]  phase_q;
  logic [dps_pkg::IDX_W-1:0]  phase_d;
  logic [dps_pkg::IDX_W:0]    phase_sum;

  logic                                s1_valid_q;
  logic [dps_pkg::IDX_W-1:0]           s1_m_q;
  logic                                s1_first_q;
  logic                                s1_last_q;
  logic [dps_pkg::IDX_W-1:0]           s1_bin_q;
  logic signed [dps_pkg::SAMPLE_W-1:0] rd_q;

  logic                                s2_valid_q;
  logic                                s2_first_q;
  logic                                s2_last_q;
  logic [dps_pkg::IDX_W-1:0]           s2_bin_q;
  logic signed [dps_pkg::PROD_W-1:0]   prod_re_q;
  logic signed [dps_pkg::PROD_W-1:0]   prod_im_q;

  logic signed [dps_pkg::ROM_W-1:0]    cos_v;
  logic signed [dps_pkg::ROM_W-1:0]    sin_v;
  logic signed [dps_pkg::ACC_W-1:0]    acc_re_q;
  logic signed [dps_pkg::ACC_W-1:0]    acc_im_q;
  logic signed [dps_pkg::ACC_W-1:0]    sum_re;
  logic signed [dps_pkg::ACC_W-1:0]    sum_im;

  logic               sums_valid_q;
  dps_pkg::bin_sums_t sums_q;

  logic adv;
  logic accept;
  logic issue;

  // The whole MAC pipeline freezes while a finished bin waits for the scaling unit.
  assign adv            = !sums_valid_q || sums_ready_i;
  assign sample_ready_o = !run_q;
  assign accept         = sample_valid_i && !run_q;
  assign issue          = run_q && adv;

  assign phase_sum = {1'b0, phase_q} + {1'b0, bin_q};
  assign phase_d   = (phase_sum >= (dps_pkg::IDX_W + 1)'(dps_pkg::POINTS))
                   ? dps_pkg::IDX_W'(phase_sum - (dps_pkg::IDX_W + 1)'(dps_pkg::POINTS))
                   : phase_sum[dps_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[cnt_q] <= sample_i;
    end
    if (issue) begin
      rd_q <= mem[j_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= 1'b0;
      cnt_q        <= '0;
      bin_q        <= '0;
      j_q          <= '0;
      phase_q      <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      sums_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (cnt_q == LAST) begin
          cnt_q <= '0;
          run_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (issue) begin
        if (j_q == LAST) begin
          j_q     <= '0;
          phase_q <= '0;
          if (bin_q == LAST) begin
            bin_q <= '0;
            run_q <= 1'b0;
          end else begin
            bin_q <= bin_q + 1'b1;
          end
        end else begin
          j_q     <= j_q + 1'b1;
          phase_q <= phase_d;
        end
      end
      if (adv) begin
        s1_valid_q <= run_q;
        s2_valid_q <= s1_valid_q;
      end
      if (sums_valid_q && sums_ready_i) begin
        sums_valid_q <= 1'b0;
      end
      if (adv && s2_valid_q && s2_last_q) begin
        sums_valid_q <= 1'b1;
      end
    end
  end

  assign cos_v  = $signed(dps_pkg::COS_ROM[s1_m_q]);
  assign sin_v  = $signed(dps_pkg::SIN_ROM[s1_m_q]);
  assign sum_re = (s2_first_q ? '0 : acc_re_q) + dps_pkg::ACC_W'(prod_re_q);
  assign sum_im = (s2_first_q ? '0 : acc_im_q) + dps_pkg::ACC_W'(prod_im_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_m_q     <= phase_q;
      s1_first_q <= (j_q == '0);
      s1_last_q  <= (j_q == LAST);
      s1_bin_q   <= bin_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_bin_q   <= s1_bin_q;
      prod_re_q  <= rd_q * cos_v;
      prod_im_q  <= rd_q * sin_v;
      if (s2_valid_q) begin
        if (s2_last_q) begin
          sums_q.bin <= s2_bin_q;
          sums_q.re  <= sum_re;
          sums_q.im  <= sum_im;
        end else begin
          acc_re_q <= sum_re;
          acc_im_q <= sum_im;
        end
      end
    end
  end

  assign sums_valid_o = sums_valid_q;
  assign sums_o       = sums_q;

endmodule

/* src/dps_post.sv */
module dps_post (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 sums_valid_i,
  output logic                                 sums_ready_o,
  input  dps_pkg::bin_sums_t                   sums_i,
  input  logic [dps_pkg::CFG_W-1:0]            step_scale_i,
  input  logic [dps_pkg::CFG_W-1:0]            inv_time_scale_i,
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic [dps_pkg::IDX_W-1:0]            bin_index_o,
  output logic signed [dps_pkg::PART_W-1:0]    real_part_o,
  output logic signed [dps_pkg::PART_W-1:0]    imag_part_o,
  output logic [dps_pkg::POW_W-1:0]            power_o,
  output logic                                 last_bin_o
);

  localparam int A_W   = dps_pkg::ACC_W;
  localparam int B_W   = dps_pkg::PART_W;
  localparam int MP_W  = A_W + B_W;
  localparam int LO_W  = 48;
  localparam int TOT_W = LO_W + 32;

  localparam logic signed [MP_W-1:0] SAT_HI = MP_W'(64'sd2147483647);
  localparam logic signed [MP_W-1:0] SAT_LO = MP_W'(-64'sd2147483648);
  localparam logic [dps_pkg::POW_W-1:0] POW_MAX = {dps_pkg::POW_W{1'b1}};

  localparam logic [3:0] P_IDLE   = 4'd0;
  localparam logic [3:0] P_MUL_RE = 4'd1;
  localparam logic [3:0] P_MUL_IM = 4'd2;
  localparam logic [3:0] P_SQ_RE  = 4'd3;
  localparam logic [3:0] P_SQ_IM  = 4'd4;
  localparam logic [3:0] P_SUM    = 4'd5;
  localparam logic [3:0] P_PW_LO  = 4'd6;
  localparam logic [3:0] P_PW_HI  = 4'd7;
  localparam logic [3:0] P_OUT    = 4'd8;

  logic [3:0] state_q;
  logic [3:0] state_d;

  dps_pkg::bin_sums_t              sums_q;
  logic signed [B_W-1:0]           re_q;
  logic signed [B_W-1:0]           im_q;
  logic [63:0]                     mag_q;
  logic [LO_W-1:0]                 lo_q;
  logic signed [A_W-1:0]           op_a;
  logic signed [B_W-1:0]           op_b;
  logic signed [MP_W-1:0]          prod_q;
  logic signed [MP_W-1:0]          shifted;
  logic signed [B_W-1:0]           sat_v;
  logic [TOT_W-1:0]                total;
  logic [dps_pkg::POW_W-1:0]       pow_v;
  logic                            out_free;
  logic                            res_valid_q;

  assign sums_ready_o = (state_q == P_IDLE);
  assign out_free     = !res_valid_q || result_ready_i;

  // Floor of the scaled sum by an arithmetic shift, then clamp to 32 bits.
  assign shifted = prod_q >>> 31;
  always_comb begin
    if (shifted > SAT_HI) begin
      sat_v = $signed(32'h7fffffff);
    end else if (shifted < SAT_LO) begin
      sat_v = $signed(32'h80000000);
    end else begin
      sat_v = shifted[B_W-1:0];
    end
  end

  // Power is built from two 32 x 16 partial products of the squared magnitude.
  assign total = {prod_q[LO_W-1:0], 32'b0} + TOT_W'(lo_q);
  assign pow_v = (|total[TOT_W-1:64]) ? POW_MAX
               : {{(dps_pkg::POW_W - LO_W){1'b0}}, total[63:16]};

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    state_d = state_q;
    unique case (state_q)
      P_IDLE: begin
        if (sums_valid_i) state_d = P_MUL_RE;
      end
      P_MUL_RE: begin
        op_a    = sums_q.re;
        op_b    = $signed({16'b0, step_scale_i});
        state_d = P_MUL_IM;
      end
      P_MUL_IM: begin
        op_a    = sums_q.im;
        op_b    = $signed({16'b0, step_scale_i});
        state_d = P_SQ_RE;
      end
      P_SQ_RE: begin
        op_a    = A_W'(re_q);
        op_b    = re_q;
        state_d = P_SQ_IM;
      end
      P_SQ_IM: begin
        op_a    = A_W'(im_q);
        op_b    = im_q;
        state_d = P_SUM;
      end
      P_SUM: begin
        state_d = P_PW_LO;
      end
      P_PW_LO: begin
        op_a    = $signed({{(A_W - 32){1'b0}}, mag_q[31:0]});
        op_b    = $signed({16'b0, inv_time_scale_i});
        state_d = P_PW_HI;
      end
      P_PW_HI: begin
        op_a    = $signed({{(A_W - 32){1'b0}}, mag_q[63:32]});
        op_b    = $signed({16'b0, inv_time_scale_i});
        state_d = P_OUT;
      end
      P_OUT: begin
        if (out_free) state_d = P_IDLE;
      end
      default: begin
        state_d = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= P_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && result_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (state_q == P_OUT && out_free) begin
        res_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // The upper partial product must survive while a finished bin waits at the output.
    if (state_q != P_OUT) begin
      prod_q <= op_a * op_b;
    end
    if (state_q == P_IDLE && sums_valid_i) begin
      sums_q <= sums_i;
    end
    if (state_q == P_MUL_IM) begin
      re_q <= sat_v;
    end
    if (state_q == P_SQ_RE) begin
      im_q <= sat_v;
    end
    if (state_q == P_SQ_IM) begin
      mag_q <= prod_q[63:0];
    end
    if (state_q == P_SUM) begin
      mag_q <= mag_q + prod_q[63:0];
    end
    if (state_q == P_PW_HI) begin
      lo_q <= prod_q[LO_W-1:0];
    end
    if (state_q == P_OUT && out_free) begin
      bin_index_o <= sums_q.bin;
      real_part_o <= re_q;
      imag_part_o <= im_q;
      power_o     <= pow_v;
      last_bin_o  <= (sums_q.bin == dps_pkg::IDX_W'(dps_pkg::POINTS - 1));
    end
  end

  assign result_valid_o = res_valid_q;

endmodule

/* src/dft_power_spectrum.sv */
// Direct DFT power spectrum over blocks of 64 samples; one sample per transaction.
// Samples are taken while the input is ready; the 64th starts the transform and
// the input stays not ready until every multiply-accumulate has been issued, one per cycle of the
// shared two-lane MAC (64 bins x 64 samples) unless a finished bin stalls it at the scaling unit.
// Bins are presented one at a time, in ascending order.
// Reset is asynchronous, active low: counters clear and both scale registers read 65535.
`include "assert_macros.svh"

module dft_power_spectrum (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dps_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [dps_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic signed [dps_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 sample_valid_i,
  output logic                                 sample_ready_o,
  output logic                                 result_valid_o,
  input  logic                                 result_ready_i,
  output logic [dps_pkg::IDX_W-1:0]            bin_index_o,
  output logic signed [dps_pkg::PART_W-1:0]    real_part_o,
  output logic signed [dps_pkg::PART_W-1:0]    imag_part_o,
  output logic [dps_pkg::POW_W-1:0]            power_o,
  output logic                                 last_bin_o
);

  logic [dps_pkg::CFG_W-1:0] step_scale_q;
  logic [dps_pkg::CFG_W-1:0] inv_time_q;

  logic               sums_valid;
  logic               sums_ready;
  dps_pkg::bin_sums_t sums;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_scale_q <= '1;
      inv_time_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dps_pkg::REG_STEP_SCALE: step_scale_q <= cfg_data_i;
        dps_pkg::REG_INV_TIME:   inv_time_q   <= cfg_data_i;
      endcase
    end
  end

  dps_mac u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sums_valid_o   (sums_valid),
    .sums_ready_i   (sums_ready),
    .sums_o         (sums)
  );

  dps_post u_post (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sums_valid_i     (sums_valid),
    .sums_ready_o     (sums_ready),
    .sums_i           (sums),
    .step_scale_i     (step_scale_q),
    .inv_time_scale_i (inv_time_q),
    .result_valid_o   (result_valid_o),
    .result_ready_i   (result_ready_i),
    .bin_index_o      (bin_index_o),
    .real_part_o      (real_part_o),
    .imag_part_o      (imag_part_o),
    .power_o          (power_o),
    .last_bin_o       (last_bin_o)
  );

  `ASSERT_ALWAYS(a_last_bin_index,
    !(result_valid_o && last_bin_o) ||
    (bin_index_o == dps_pkg::IDX_W'(dps_pkg::POINTS - 1)),
    "last bin flag on a bin other than the final one")
  `ASSERT_PROP(a_ready_falls_on_sample,
    $fell(sample_ready_o) |-> $past(sample_valid_i && sample_ready_o),
    "input went busy without a sample transaction")
  `ASSERT_PROP(a_post_busy_after_take,
    (sums_valid && sums_ready) |=> !sums_ready,
    "scaling unit still idle after taking a bin")
  `ASSERT_PROP(a_sums_held,
    (sums_valid && !sums_ready) |=> (sums_valid && $stable(sums)),
    "bin sums changed before the scaling unit took them")

endmodule
